### hw/rtl/siq_pkg.sv
package siq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int TIME_BITS   = 32;
	localparam int ID_W        = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int UTIME_W     = TIME_BITS - 1;

	typedef enum logic [2:0] {
		CMD_APPEND  = 3'd0,
		CMD_SORTED  = 3'd1,
		CMD_REMOVE  = 3'd2,
		CMD_AGE_BLK = 3'd3,
		CMD_AGE_WAI = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_EMPTY = 2'd2
	} err_t;

	// what every cell does
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INSERT,
		OP_REMOVE,
		OP_AGE_BLK,
		OP_AGE_WAI
	} op_t;

	typedef struct packed {
		logic [ID_W-1:0]             id;
		logic signed [TIME_BITS-1:0] blocking;
		logic [UTIME_W-1:0]          burst;
		logic [UTIME_W-1:0]          waiting;
	} entry_t;

	typedef struct packed {
		op_t                op;
		logic               sorted;
		logic               key_sel;
		logic [UTIME_W-1:0] elapsed;
	} cell_ctl_t;

endpackage

### hw/rtl/siq_cell.sv
module siq_cell
	import siq_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  entry_t    new_entry,
	input  entry_t    left_entry,
	input  entry_t    right_entry,
	input  logic      occupied,
	input  logic      found_in,
	output logic      found_out,
	output entry_t    entry
);

	entry_t               entry_q;
	logic                 greater;
	logic                 hit;
	logic [TIME_BITS:0]   diff;
	logic [TIME_BITS-1:0] sum;
	logic signed [TIME_BITS-1:0] blk_aged;
	logic [UTIME_W-1:0]   wai_aged;

	always_comb begin
		if (ctl.key_sel) begin
			greater = new_entry.burst < entry_q.burst;
		end else begin
			greater = $signed(new_entry.blocking) < $signed(entry_q.blocking);
		end
		// first cell that is empty or, for a sorted insert, holds a strictly greater key takes the request
		hit       = !occupied || (ctl.sorted && greater);
		found_out = found_in || hit;
	end

	always_comb begin
		diff = {entry_q.blocking[TIME_BITS-1], entry_q.blocking} - {2'b00, ctl.elapsed};
		if (diff[TIME_BITS] != diff[TIME_BITS-1]) begin
			blk_aged = {1'b1, {(TIME_BITS-1){1'b0}}};
		end else begin
			blk_aged = diff[TIME_BITS-1:0];
		end
		sum = {1'b0, entry_q.waiting} + {1'b0, ctl.elapsed};
		if (sum[TIME_BITS-1]) begin
			wai_aged = {UTIME_W{1'b1}};
		end else begin
			wai_aged = sum[UTIME_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_INSERT: begin
				if (found_in) begin
					entry_q <= left_entry;
				end else if (hit) begin
					entry_q <= new_entry;
				end
			end
			OP_REMOVE:  entry_q <= right_entry;
			OP_AGE_BLK: entry_q.blocking <= blk_aged;
			OP_AGE_WAI: entry_q.waiting <= wai_aged;
			default: ;
		endcase
	end

	assign entry = entry_q;

endmodule

### hw/rtl/sorted_insert_process_queue_top.sv
// A request accepted at one edge has its result, marked by done, in the next cycle.
// One request per cycle; all cells of the row shift or age together, the clock rate being
// limited by the insert-position ripple through the QUEUE_DEPTH cells. busy stays low.
// The receiver cannot stall: every result is shown for exactly one cycle.
// Reset clears the entry count, done, removed_valid and the error code; entry contents are left as they are.
module sorted_insert_process_queue_top
	import siq_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [2:0]                  cmd,
	input  logic [ID_W-1:0]             process_id,
	input  logic [UTIME_W-1:0]          burst_time,
	input  logic signed [TIME_BITS-1:0] blocking_time,
	input  logic [UTIME_W-1:0]          waiting_time,
	input  logic                        key_select,
	input  logic [UTIME_W-1:0]          elapsed_time,
	output logic                        done,
	output logic [ID_W-1:0]             head_id,
	output logic signed [TIME_BITS-1:0] head_blocking,
	output logic [UTIME_W-1:0]          head_burst,
	output logic [UTIME_W-1:0]          head_waiting,
	output logic                        removed_valid,
	output logic                        is_empty,
	output logic [CNT_W-1:0]            entry_count,
	output logic [1:0]                  error_code
);

	logic [CNT_W-1:0] fill_q;
	logic             done_q;
	logic             removed_q;
	err_t             err_q;
	entry_t           head_q;

	cmd_t             cmd_e;
	logic             full;
	logic             empty;
	cell_ctl_t        ctl;
	err_t             err_d;
	entry_t           new_entry;
	entry_t           cell_data [QUEUE_DEPTH];
	logic [QUEUE_DEPTH:0] found;
	logic [QUEUE_DEPTH-1:0] occupied;

	assign busy  = 1'b0;
	assign cmd_e = cmd_t'(cmd);
	assign full  = fill_q == CNT_W'(QUEUE_DEPTH);
	assign empty = fill_q == '0;

	assign new_entry = '{id: process_id, blocking: blocking_time,
	                     burst: burst_time, waiting: waiting_time};

	always_comb begin
		ctl.op      = OP_HOLD;
		ctl.sorted  = cmd_e == CMD_SORTED;
		ctl.key_sel = key_select;
		ctl.elapsed = elapsed_time;
		err_d       = ERR_NONE;
		if (start) begin
			case (cmd_e) inside
				CMD_APPEND, CMD_SORTED: begin
					if (full) begin
						err_d = ERR_FULL;
					end else begin
						ctl.op = OP_INSERT;
					end
				end
				CMD_REMOVE: begin
					if (empty) begin
						err_d = ERR_EMPTY;
					end else begin
						ctl.op = OP_REMOVE;
					end
				end
				CMD_AGE_BLK: ctl.op = OP_AGE_BLK;
				CMD_AGE_WAI: ctl.op = OP_AGE_WAI;
				default: ;
			endcase
		end
	end

	assign found[0] = 1'b0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		assign occupied[i] = CNT_W'(i) < fill_q;
		siq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.new_entry   (new_entry),
			.left_entry  (cell_data[(i == 0) ? 0 : i - 1]),
			.right_entry (cell_data[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
			.occupied    (occupied[i]),
			.found_in    (found[i]),
			.found_out   (found[i+1]),
			.entry       (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			done_q    <= 1'b0;
			removed_q <= 1'b0;
			err_q     <= ERR_NONE;
		end else begin
			done_q    <= start;
			removed_q <= ctl.op == OP_REMOVE;
			err_q     <= err_d;
			case (ctl.op)
				OP_INSERT: fill_q <= fill_q + 1'b1;
				OP_REMOVE: fill_q <= fill_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_REMOVE) begin
			head_q <= cell_data[0];
		end else begin
			head_q <= '0;
		end
	end

	assign done          = done_q;
	assign head_id       = head_q.id;
	assign head_blocking = head_q.blocking;
	assign head_burst    = head_q.burst;
	assign head_waiting  = head_q.waiting;
	assign removed_valid = removed_q;
	assign is_empty      = empty;
	assign entry_count   = fill_q;
	assign error_code    = err_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count beyond queue depth");

	a_removed_done: assert property (@(posedge clk) disable iff (!arst_n)
		removed_valid |-> (done && error_code == ERR_NONE))
		else $error("removed entry without a request result");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(start && (cmd == CMD_APPEND || cmd == CMD_SORTED) && full)
		|=> (error_code == ERR_FULL && $stable(fill_q)))
		else $error("insert into full queue not dropped");

	a_empty_remove: assert property (@(posedge clk) disable iff (!arst_n)
		(start && cmd == CMD_REMOVE && empty)
		|=> (error_code == ERR_EMPTY && !removed_valid && head_id == '0))
		else $error("remove on empty queue mishandled");

	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		(start && cmd == CMD_REMOVE && !empty) |=> (fill_q == $past(fill_q) - 1'b1))
		else $error("remove did not shrink the queue");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import siq_pkg::*;

	localparam logic [2:0] CMD_UNUSED_5 = 3'd5;
	localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
	localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

	localparam logic signed [TIME_BITS-1:0] BLK_MIN = {1'b1, {(TIME_BITS-1){1'b0}}};
	localparam logic signed [TIME_BITS-1:0] BLK_MAX = {1'b0, {(TIME_BITS-1){1'b1}}};
	localparam logic [UTIME_W-1:0] UT_MAX = {UTIME_W{1'b1}};
	localparam longint BLK_MIN_L = -(longint'(1) << (TIME_BITS-1));
	localparam longint UT_MAX_L = (longint'(1) << (TIME_BITS-1)) - 1;

	typedef struct packed {
		logic [2:0]         op;
		entry_t             ent;
		logic               key;
		logic [UTIME_W-1:0] elapsed;
	} request_t;

	typedef struct packed {
		entry_t           head;
		logic             removed;
		logic             empty;
		logic [CNT_W-1:0] count;
		err_t             err;
	} result_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [2:0] cmd;
	logic [ID_W-1:0] process_id;
	logic [UTIME_W-1:0] burst_time;
	logic signed [TIME_BITS-1:0] blocking_time;
	logic [UTIME_W-1:0] waiting_time;
	logic key_select;
	logic [UTIME_W-1:0] elapsed_time;
	logic done;
	logic [ID_W-1:0] head_id;
	logic signed [TIME_BITS-1:0] head_blocking;
	logic [UTIME_W-1:0] head_burst;
	logic [UTIME_W-1:0] head_waiting;
	logic removed_valid;
	logic is_empty;
	logic [CNT_W-1:0] entry_count;
	logic [1:0] error_code;

	// predicted queue contents
	entry_t queue_slots [QUEUE_DEPTH];
	int fill_level;
	result_t pending_results[$];
	int mismatch_count;
	bit gaps_enabled;

	sorted_insert_process_queue_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.process_id(process_id),
		.burst_time(burst_time),
		.blocking_time(blocking_time),
		.waiting_time(waiting_time),
		.key_select(key_select),
		.elapsed_time(elapsed_time),
		.done(done),
		.head_id(head_id),
		.head_blocking(head_blocking),
		.head_burst(head_burst),
		.head_waiting(head_waiting),
		.removed_valid(removed_valid),
		.is_empty(is_empty),
		.entry_count(entry_count),
		.error_code(error_code)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		if (mismatch_count < 40)
			$display("%0t: mismatch %s: got %h want %h", $time, what, got, want);
		mismatch_count++;
	endtask

	// queue behavior for one request; pushes the expected result
	task apply_queue_cmd(input request_t r);
		result_t res;
		int pos;
		longint acc;
		bit greater;
		res = '0;
		case (r.op)
			CMD_APPEND, CMD_SORTED: begin
				if (fill_level >= QUEUE_DEPTH) begin
					res.err = ERR_FULL;
				end else begin
					pos = fill_level;
					// walk backward so pos ends on the first strictly greater key
					if (r.op == CMD_SORTED)
						for (int i = fill_level - 1; i >= 0; i--) begin
							if (r.key)
								greater = r.ent.burst < queue_slots[i].burst;
							else
								greater = $signed(r.ent.blocking) < $signed(queue_slots[i].blocking);
							if (greater)
								pos = i;
						end
					for (int k = fill_level; k > pos; k--)
						queue_slots[k] = queue_slots[k-1];
					queue_slots[pos] = r.ent;
					fill_level++;
				end
			end
			CMD_REMOVE: begin
				if (fill_level == 0) begin
					res.err = ERR_EMPTY;
				end else begin
					res.head = queue_slots[0];
					res.removed = 1'b1;
					for (int k = 0; k + 1 < fill_level; k++)
						queue_slots[k] = queue_slots[k+1];
					fill_level--;
				end
			end
			CMD_AGE_BLK: begin
				for (int i = 0; i < fill_level; i++) begin
					acc = longint'($signed(queue_slots[i].blocking)) - longint'(r.elapsed);
					if (acc < BLK_MIN_L)
						acc = BLK_MIN_L;
					queue_slots[i].blocking = acc[TIME_BITS-1:0];
				end
			end
			CMD_AGE_WAI: begin
				for (int i = 0; i < fill_level; i++) begin
					acc = longint'(queue_slots[i].waiting) + longint'(r.elapsed);
					if (acc > UT_MAX_L)
						acc = UT_MAX_L;
					queue_slots[i].waiting = acc[UTIME_W-1:0];
				end
			end
			default: ;
		endcase
		res.empty = (fill_level == 0);
		res.count = fill_level[CNT_W-1:0];
		pending_results.push_back(res);
	endtask

	task send_request(input request_t r);
		if (gaps_enabled && $urandom_range(0, 99) < 30) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(0, 3)) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		cmd <= r.op;
		process_id <= r.ent.id;
		burst_time <= r.ent.burst;
		blocking_time <= r.ent.blocking;
		waiting_time <= r.ent.waiting;
		key_select <= r.key;
		elapsed_time <= r.elapsed;
		do @(posedge clk); while (busy);
		apply_queue_cmd(r);
	endtask

	task wait_drained;
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic request_t build_request(input logic [2:0] op, input logic [ID_W-1:0] id,
			input logic signed [TIME_BITS-1:0] blk, input logic [UTIME_W-1:0] bur,
			input logic [UTIME_W-1:0] wai, input logic key, input logic [UTIME_W-1:0] el);
		request_t r;
		r.op = op;
		r.ent.id = id;
		r.ent.blocking = blk;
		r.ent.burst = bur;
		r.ent.waiting = wai;
		r.key = key;
		r.elapsed = el;
		return r;
	endfunction

	// small values make equal keys common
	function automatic logic [UTIME_W-1:0] rand_utime();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return UT_MAX;
			2, 3, 4, 5: return UTIME_W'($urandom_range(0, 15));
			default: return UTIME_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [TIME_BITS-1:0] rand_btime();
		case ($urandom_range(0, 9))
			0: return BLK_MIN;
			1: return BLK_MAX;
			2, 3, 4, 5: return $signed($urandom_range(0, 16)) - 8;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [UTIME_W-1:0] rand_elapsed();
		case ($urandom_range(0, 9))
			0: return UT_MAX;
			1: return UTIME_W'($urandom);
			default: return UTIME_W'($urandom_range(0, 15));
		endcase
	endfunction

	function automatic request_t rand_request(input logic [2:0] op);
		return build_request(op, ID_W'($urandom), rand_btime(), rand_utime(), rand_utime(),
			1'($urandom_range(0, 1)), rand_elapsed());
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request pending", done, 0);
			end else begin
				want = pending_results.pop_front();
				if (head_id !== want.head.id)
					report_mismatch("head_id", head_id, want.head.id);
				if (head_blocking !== want.head.blocking)
					report_mismatch("head_blocking", head_blocking, want.head.blocking);
				if (head_burst !== want.head.burst)
					report_mismatch("head_burst", head_burst, want.head.burst);
				if (head_waiting !== want.head.waiting)
					report_mismatch("head_waiting", head_waiting, want.head.waiting);
				if (removed_valid !== want.removed)
					report_mismatch("removed_valid", removed_valid, want.removed);
				if (is_empty !== want.empty)
					report_mismatch("is_empty", is_empty, want.empty);
				if (entry_count !== want.count)
					report_mismatch("entry_count", entry_count, want.count);
				if (error_code !== want.err)
					report_mismatch("error_code", error_code, want.err);
			end
		end
	end

	task test_directed;
		send_request(build_request(CMD_REMOVE, 16'h1234, 0, 0, 0, 0, 0));
		send_request(build_request(CMD_AGE_BLK, 0, 0, 0, 0, 0, UT_MAX));
		send_request(build_request(CMD_AGE_WAI, 0, 0, 0, 0, 1, UT_MAX));
		send_request(rand_request(CMD_UNUSED_5));
		send_request(rand_request(CMD_UNUSED_6));
		send_request(rand_request(CMD_UNUSED_7));
		send_request(build_request(CMD_APPEND, 16'hFFFF, BLK_MAX, UT_MAX, UT_MAX, 1, UT_MAX));
		send_request(build_request(CMD_APPEND, 16'h0000, BLK_MIN, 0, 0, 0, 0));
		send_request(build_request(CMD_SORTED, 16'h0010, 0, 7, 3, 0, 0));
		// equal blocking key lands behind the earlier one
		send_request(build_request(CMD_SORTED, 16'h0011, 0, 9, 4, 0, 0));
		send_request(build_request(CMD_SORTED, 16'h0020, 5, 5, 1, 1, 0));
		send_request(build_request(CMD_SORTED, 16'h0021, -5, 5, 2, 1, 0));
		send_request(build_request(CMD_AGE_WAI, 0, 0, 0, 0, 0, UT_MAX - 1));
		// pushes the most negative entry past the bottom
		send_request(build_request(CMD_AGE_BLK, 0, 0, 0, 0, 0, UT_MAX));
		send_request(build_request(CMD_SORTED, 16'h0030, BLK_MIN, 1, 0, 0, 0));
		repeat (7)
			send_request(build_request(CMD_REMOVE, 0, 0, 0, 0, 0, 0));
		send_request(build_request(CMD_REMOVE, 0, 0, 0, 0, 0, 0));
	endtask

	task test_fill_to_full;
		wait_drained();
		while (fill_level < QUEUE_DEPTH)
			send_request(rand_request($urandom_range(0, 1) ? CMD_SORTED : CMD_APPEND));
		repeat (3)
			send_request(rand_request($urandom_range(0, 1) ? CMD_SORTED : CMD_APPEND));
		send_request(rand_request(CMD_AGE_BLK));
		send_request(rand_request(CMD_AGE_WAI));
		while (fill_level > 0)
			send_request(rand_request(CMD_REMOVE));
		send_request(rand_request(CMD_REMOVE));
	endtask

	task test_random_mix(input int n_requests, input bit gaps);
		bit filling;
		int roll;
		logic [2:0] op;
		gaps_enabled = gaps;
		filling = 1'b1;
		for (int n = 0; n < n_requests; n++) begin
			if (n % 40 == 39)
				filling = ~filling;
			roll = $urandom_range(0, 99);
			if (filling)
				op = roll < 30 ? CMD_APPEND : roll < 60 ? CMD_SORTED : roll < 72 ? CMD_REMOVE :
					roll < 84 ? CMD_AGE_BLK : roll < 96 ? CMD_AGE_WAI : CMD_UNUSED_5;
			else
				op = roll < 10 ? CMD_APPEND : roll < 20 ? CMD_SORTED : roll < 70 ? CMD_REMOVE :
					roll < 80 ? CMD_AGE_BLK : roll < 90 ? CMD_AGE_WAI : CMD_UNUSED_5;
			if (op == CMD_UNUSED_5)
				op = op + 3'($urandom_range(0, 2));
			send_request(rand_request(op));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_APPEND;
		process_id = '0;
		burst_time = '0;
		blocking_time = '0;
		waiting_time = '0;
		key_select = 1'b0;
		elapsed_time = '0;
		fill_level = 0;
		mismatch_count = 0;
		gaps_enabled = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_fill_to_full();
		test_random_mix(225, 1'b1);
		gaps_enabled = 1'b0;
		test_fill_to_full();
		test_random_mix(225, 1'b0);
		gaps_enabled = 1'b1;
		test_fill_to_full();
		test_random_mix(225, 1'b1);

		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

### sorted_insert_process_queue_top.f
hw/rtl/siq_pkg.sv
hw/rtl/siq_cell.sv
hw/rtl/sorted_insert_process_queue_top.sv
tb/testbench.sv
